// ----- rtl/core/recursive_median_filter_framed_defines.svh -----
// Assertion macros used by the checker file.
// Both expect signals named clk and rst_n in the scope of use.
`ifndef RECURSIVE_MEDIAN_FILTER_FRAMED_DEFINES_SVH
`define RECURSIVE_MEDIAN_FILTER_FRAMED_DEFINES_SVH

// Check a consequence in the cycle after the antecedent
`define RMF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("median filter check failed");

// Check a consequence in the same cycle as the antecedent
`define RMF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("median filter check failed");

`endif

// ----- rtl/core/rmf_pkg.sv -----
package rmf_pkg;

    localparam int SAMPLE_W     = 24;
    localparam int CFG_W        = 8;
    localparam int MAX_WINDOW   = 9;
    localparam int MIN_WINDOW   = 3;
    localparam logic [CFG_W-1:0] WINDOW_RESET = 8'd5;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Word handed from one sort cell to its right neighbor
    typedef struct packed {
        logic    valid;
        logic    shift;
        sample_t value;
    } rmf_link_t;

    // Commands broadcast to every sort cell
    typedef struct packed {
        logic clear;
        logic insert;
    } rmf_sort_ctl_t;

endpackage

// ----- rtl/core/rmf_channels.sv -----
interface rmf_sample_if;
    logic              valid;
    logic              ready;
    rmf_pkg::sample_t  sample;
    logic              last_in_frame;

    modport source (output valid, output sample, output last_in_frame, input ready);
    modport sink   (input valid, input sample, input last_in_frame, output ready);
endinterface

interface rmf_result_if;
    logic              valid;
    logic              ready;
    rmf_pkg::sample_t  filtered_sample;
    logic              frame_end;

    modport source (output valid, output filtered_sample, output frame_end, input ready);
    modport sink   (input valid, input filtered_sample, input frame_end, output ready);
endinterface

// ----- rtl/core/rmf_sort_cell.sv -----
module rmf_sort_cell
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rmf_pkg::rmf_sort_ctl_t ctl,
    input  rmf_pkg::sample_t      din,
    input  rmf_pkg::rmf_link_t    left,
    output rmf_pkg::rmf_link_t    right
);

    logic             valid_reg;
    logic             valid_next;
    rmf_pkg::sample_t value_reg;
    rmf_pkg::sample_t value_next;
    logic             lt;

    // An empty cell counts as larger than anything
    assign lt = !valid_reg || (din < value_reg);

    assign right.valid = valid_reg;
    assign right.shift = lt;
    assign right.value = value_reg;

    // Take the left neighbor when it moves right, else take the new word
    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.insert && lt)
        begin
            valid_next = left.shift ? left.valid : 1'b1;
            value_next = left.shift ? left.value : din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ----- rtl/core/rmf_sorter.sv -----
module rmf_sorter
#(
    parameter int DEPTH = rmf_pkg::MAX_WINDOW
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  rmf_pkg::rmf_sort_ctl_t      ctl,
    input  rmf_pkg::sample_t            din,
    input  logic [$clog2(DEPTH)-1:0]    sel,
    output rmf_pkg::sample_t            dout
);

    rmf_pkg::rmf_link_t links [DEPTH];
    rmf_pkg::rmf_link_t head;

    // The leftmost cell never takes from a neighbor
    assign head = '{valid: 1'b0, shift: 1'b0, value: '0};

    // Row of insertion cells, kept in ascending order
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        rmf_sort_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .din   (din),
            .left  ((k == 0) ? head : links[(k == 0) ? 0 : k - 1]),
            .right (links[k])
        );
    end

    // Pick the element at the requested rank
    assign dout = links[sel].value;

endmodule

// ----- rtl/core/recursive_median_filter_framed.sv -----
// Recursive median filter over framed signed 24-bit samples.
// samples: valid/ready channel carrying sample and last_in_frame. A word is
//   taken when valid and ready are both high; ready is high only while the
//   filter is idle, so one word is processed at a time.
// results: valid/ready channel carrying filtered_sample and frame_end, fed
//   from a single output register. A stalled receiver holds that register and
//   the filter waits before loading the next result; input is still taken
//   once the current word's work is done.
// cfg_wr_en/cfg_wr_data write the window length; write it only when idle.
// Sequence: a check after each taken word decides whether a result is due.
//   For each median the row of sort cells is cleared, the window words are
//   inserted in turn and the median is emitted; the check then runs again,
//   so a word that closes a frame yields every pending result. Pass-through
//   (W below 3) sends held words, then the new one, whenever the output is free.
// Reset clears the output history to zero, drops pending words, sets the
//   window to 5 and empties the output register.
module recursive_median_filter_framed
#(
    parameter int MAX_WINDOW = rmf_pkg::MAX_WINDOW
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    rmf_sample_if.sink                  samples,
    rmf_result_if.source                results,
    input  logic                        cfg_wr_en,
    input  logic [rmf_pkg::CFG_W-1:0]   cfg_wr_data
);

    localparam int HIST_DEPTH = MAX_WINDOW / 2;
    localparam int RAW_DEPTH  = MAX_WINDOW - HIST_DEPTH;
    localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
    localparam int CNT_W      = $clog2(RAW_DEPTH + 1);
    localparam int SEL_W      = $clog2(MAX_WINDOW);
    localparam int HIST_IDX_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int RAW_IDX_W  = $clog2(RAW_DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PASS  = 5'b00010,
        ST_CHECK = 5'b00100,
        ST_SORT  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic [rmf_pkg::CFG_W-1:0]  median_window_reg;
    logic [WIN_W-1:0]           win_reg, win_next;
    logic [WIN_W-1:0]           half_reg, half_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [CNT_W-1:0]           pass_idx_reg, pass_idx_next;
    logic [WIN_W-1:0]           feed_idx_reg, feed_idx_next;
    logic                       last_reg, last_next;
    rmf_pkg::sample_t           hold_reg, hold_next;
    logic                       out_valid_reg, out_valid_next;
    rmf_pkg::sample_t           out_sample_reg, out_sample_next;
    logic                       out_end_reg, out_end_next;

    rmf_pkg::sample_t           hist_reg    [HIST_DEPTH];
    rmf_pkg::sample_t           pending_reg [RAW_DEPTH];

    logic                       accept;
    logic                       slot_free;
    logic [WIN_W-1:0]           win_clamped;
    logic                       pass_now;
    logic [WIN_W-1:0]           look;
    logic                       due;
    logic                       emit_fire;
    logic [WIN_W-1:0]           raw_off;
    logic [CNT_W-1:0]           cnt_m1;
    logic [CNT_W-1:0]           raw_pick;
    rmf_pkg::sample_t           feed_word;
    rmf_pkg::sample_t           median;
    rmf_pkg::rmf_sort_ctl_t     sort_ctl;

    assign samples.ready           = (state_reg == ST_IDLE);
    assign accept                  = samples.valid && samples.ready;
    assign slot_free               = !out_valid_reg || results.ready;
    assign results.valid           = out_valid_reg;
    assign results.filtered_sample = out_sample_reg;
    assign results.frame_end       = out_end_reg;

    // Clamp the window register to the row length
    assign win_clamped = (median_window_reg > rmf_pkg::CFG_W'(MAX_WINDOW))
                       ? WIN_W'(MAX_WINDOW) : median_window_reg[WIN_W-1:0];
    assign pass_now    = win_clamped < WIN_W'(rmf_pkg::MIN_WINDOW);

    // Decide whether the oldest pending word has enough look-ahead
    assign look = win_reg - half_reg - WIN_W'(1);
    assign due  = (WIN_W'(cnt_reg) > look) || (last_reg && (cnt_reg != '0));

    // Select the window word to insert: history first, then raw words
    assign raw_off = feed_idx_reg - half_reg;
    assign cnt_m1  = cnt_reg - CNT_W'(1);

    always_comb
    begin
        if (raw_off > WIN_W'(cnt_m1))
        begin
            raw_pick = cnt_m1;
        end
        else
        begin
            raw_pick = raw_off[CNT_W-1:0];
        end
        if (feed_idx_reg < half_reg)
        begin
            feed_word = hist_reg[feed_idx_reg[HIST_IDX_W-1:0]];
        end
        else
        begin
            feed_word = pending_reg[raw_pick[RAW_IDX_W-1:0]];
        end
    end

    assign sort_ctl.clear  = (state_reg == ST_CHECK) && due;
    assign sort_ctl.insert = (state_reg == ST_SORT);
    assign emit_fire       = (state_reg == ST_EMIT) && slot_free;

    rmf_sorter
    #(
        .DEPTH (MAX_WINDOW)
    )
    u_sorter
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (sort_ctl),
        .din   (feed_word),
        .sel   (half_reg[SEL_W-1:0]),
        .dout  (median)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        win_next        = win_reg;
        half_next       = half_reg;
        cnt_next        = cnt_reg;
        pass_idx_next   = pass_idx_reg;
        feed_idx_next   = feed_idx_reg;
        last_next       = last_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_sample_next = out_sample_reg;
        out_end_next    = out_end_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    win_next      = win_clamped;
                    half_next     = win_clamped >> 1;
                    last_next     = samples.last_in_frame;
                    hold_next     = samples.sample;
                    pass_idx_next = '0;
                    if (pass_now)
                    begin
                        state_next = ST_PASS;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + CNT_W'(1);
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_PASS:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (pass_idx_reg < cnt_reg)
                    begin
                        out_sample_next = pending_reg[pass_idx_reg[RAW_IDX_W-1:0]];
                        out_end_next    = 1'b0;
                        pass_idx_next   = pass_idx_reg + CNT_W'(1);
                    end
                    else
                    begin
                        out_sample_next = hold_reg;
                        out_end_next    = last_reg;
                        cnt_next        = '0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            ST_CHECK:
            begin
                feed_idx_next = '0;
                state_next    = due ? ST_SORT : ST_IDLE;
            end
            ST_SORT:
            begin
                feed_idx_next = feed_idx_reg + WIN_W'(1);
                if (feed_idx_reg == win_reg - WIN_W'(1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = median;
                    out_end_next    = last_reg && (cnt_reg == CNT_W'(1));
                    cnt_next        = cnt_reg - CNT_W'(1);
                    state_next      = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            median_window_reg <= rmf_pkg::WINDOW_RESET;
            cnt_reg           <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                median_window_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        win_reg        <= win_next;
        half_reg       <= half_next;
        pass_idx_reg   <= pass_idx_next;
        feed_idx_reg   <= feed_idx_next;
        last_reg       <= last_next;
        hold_reg       <= hold_next;
        out_sample_reg <= out_sample_next;
        out_end_reg    <= out_end_next;
    end

    // Output history: push each median, most recent first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < HIST_DEPTH; k++)
            begin
                hist_reg[k] <= '0;
            end
        end
        else if (emit_fire)
        begin
            hist_reg[0] <= median;
            for (int k = 1; k < HIST_DEPTH; k++)
            begin
                hist_reg[k] <= hist_reg[k-1];
            end
        end
    end

    // Pending raw words: append on accept outside pass-through, drop the oldest on emit
    always_ff @(posedge clk)
    begin
        if (accept && !pass_now)
        begin
            pending_reg[cnt_reg[RAW_IDX_W-1:0]] <= samples.sample;
        end
        else if (emit_fire)
        begin
            for (int k = 1; k < RAW_DEPTH; k++)
            begin
                pending_reg[k-1] <= pending_reg[k];
            end
        end
    end

endmodule

// ----- rtl/core/rmf_checker.sv -----
`include "recursive_median_filter_framed_defines.svh"

module rmf_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input rmf_pkg::sample_t out_sample,
    input logic             out_end
);

    // One word at a time: input closes right after a word is taken
    `RMF_ASSERT_NEXT(a_one_word, in_valid && in_ready, !in_ready)

    // A stalled result holds its word
    `RMF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_sample) && $stable(out_end))

    // No result shows in the first cycle after reset
    `RMF_ASSERT_SAME(a_reset_quiet, !$past(rst_n), !out_valid)

endmodule

bind recursive_median_filter_framed rmf_checker u_rmf_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (samples.valid),
    .in_ready   (samples.ready),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .out_sample (results.filtered_sample),
    .out_end    (results.frame_end)
);

// ----- sim/recursive_median_filter_framed_tb.sv -----
`timescale 1ns / 1ps

module recursive_median_filter_framed_tb;

    localparam int HIST_DEPTH       = rmf_pkg::MAX_WINDOW / 2;
    localparam int RAW_DEPTH        = rmf_pkg::MAX_WINDOW - rmf_pkg::MAX_WINDOW / 2;
    localparam int SETTLE_CYCLES    = 30;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS     = 205;

    typedef struct packed {
        rmf_pkg::sample_t value;
        logic             frame_last;
    } sample_word_t;

    typedef struct packed {
        rmf_pkg::sample_t value;
        logic             frame_end;
    } result_word_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [rmf_pkg::CFG_W-1:0] cfg_wr_data;

    rmf_sample_if sample_ch ();
    rmf_result_if result_ch ();

    recursive_median_filter_framed DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (sample_ch),
        .results     (result_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Words waiting to be sent and filter outputs still due
    sample_word_t send_q[$];
    result_word_t due_results[$];

    // Shadow of the filter: output history, held raw words, window register
    rmf_pkg::sample_t          out_history [HIST_DEPTH];
    rmf_pkg::sample_t          held_raw [RAW_DEPTH];
    int                        held_count;
    logic [rmf_pkg::CFG_W-1:0] window_reg;

    int mismatch_count;
    int send_gap;
    int recv_gap;
    int hold_cycles;
    bit steady;

    always #10 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int rand_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic rmf_pkg::sample_t pick_sample();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0: return rmf_pkg::sample_t'(24'h7FFFFF);
            1: return rmf_pkg::sample_t'(24'h800000);
            2, 3: return rmf_pkg::sample_t'(int'($urandom_range(0, 31)) - 16);
            default: return rmf_pkg::sample_t'($urandom);
        endcase
    endfunction

    function automatic int frame_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 6);
        else if (r < 95)
            return $urandom_range(7, 15);
        else
            return $urandom_range(16, 40);
    endfunction

    // Median at sorted index h of history plus look-ahead of the oldest held word
    function automatic rmf_pkg::sample_t median_of_oldest(input int w, input int h);
        rmf_pkg::sample_t win [rmf_pkg::MAX_WINDOW];
        rmf_pkg::sample_t key;
        int               n;
        int               idx;
        int               j;
        n = 0;
        for (int k = 0; k < h && k < HIST_DEPTH; k++)
        begin
            win[n] = out_history[k];
            n++;
        end
        for (int k = 0; k < w - h && n < rmf_pkg::MAX_WINDOW; k++)
        begin
            idx = (k < held_count) ? k : held_count - 1;
            if (idx >= RAW_DEPTH)
                idx = RAW_DEPTH - 1;
            win[n] = held_raw[idx];
            n++;
        end
        for (int k = 1; k < n; k++)
        begin
            key = win[k];
            j = k;
            while (j > 0 && win[j-1] > key)
            begin
                win[j] = win[j-1];
                j--;
            end
            win[j] = key;
        end
        return win[(h < n) ? h : n - 1];
    endfunction

    // Advance the shadow filter by one accepted word and queue its outputs
    task automatic predict_medians(input rmf_pkg::sample_t s, input logic frame_last);
        int               w;
        int               h;
        int               look;
        logic             fin;
        rmf_pkg::sample_t m;
        w = (window_reg > rmf_pkg::MAX_WINDOW) ? rmf_pkg::MAX_WINDOW : int'(window_reg);
        if (w < rmf_pkg::MIN_WINDOW)
        begin
            // Pass-through: flush held words unchanged, then the new one
            for (int k = 0; k < held_count && k < RAW_DEPTH; k++)
                due_results.push_back('{held_raw[k], 1'b0});
            held_count = 0;
            due_results.push_back('{s, frame_last});
            return;
        end
        h = w / 2;
        look = w - h - 1;
        if (held_count < RAW_DEPTH)
        begin
            held_raw[held_count] = s;
            held_count++;
        end
        else
            held_raw[RAW_DEPTH-1] = s;
        while (held_count > look || (frame_last && held_count > 0))
        begin
            fin = frame_last && held_count == 1;
            m = median_of_oldest(w, h);
            due_results.push_back('{m, fin});
            for (int k = HIST_DEPTH - 1; k > 0; k--)
                out_history[k] = out_history[k-1];
            out_history[0] = m;
            for (int k = 1; k < held_count && k < RAW_DEPTH; k++)
                held_raw[k-1] = held_raw[k];
            held_count--;
        end
    endtask

    // Sample driver: hold a word until taken, then idle or present the next
    always @(posedge clk)
    begin : drive_samples
        sample_word_t nxt;
        if (sample_ch.valid && sample_ch.ready)
            predict_medians(sample_ch.sample, sample_ch.last_in_frame);
        if (sample_ch.valid && !sample_ch.ready)
        begin
            // hold the current word
        end
        else if (send_gap > 0)
        begin
            send_gap--;
            sample_ch.valid <= 1'b0;
        end
        else if (send_q.size() > 0)
        begin
            nxt = send_q.pop_front();
            sample_ch.valid         <= 1'b1;
            sample_ch.sample        <= nxt.value;
            sample_ch.last_in_frame <= nxt.frame_last;
            send_gap = steady ? 0 : rand_gap();
        end
        else
            sample_ch.valid <= 1'b0;
    end

    // Result monitor: check each taken word, then pick the next ready level
    always @(posedge clk)
    begin : check_results
        result_word_t want;
        if (result_ch.valid && result_ch.ready)
        begin
            if (due_results.size() == 0)
            begin
                $error("unexpected result word: filtered_sample %0d frame_end %0b",
                       $signed(result_ch.filtered_sample), result_ch.frame_end);
                mismatch_count++;
            end
            else
            begin
                want = due_results.pop_front();
                if (result_ch.filtered_sample !== want.value)
                begin
                    $error("filtered_sample: expected %0d, actual %0d",
                           $signed(want.value), $signed(result_ch.filtered_sample));
                    mismatch_count++;
                end
                if (result_ch.frame_end !== want.frame_end)
                begin
                    $error("frame_end: expected %0b, actual %0b",
                           want.frame_end, result_ch.frame_end);
                    mismatch_count++;
                end
            end
            if (!steady)
                recv_gap = rand_gap();
        end
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles--;
            result_ch.ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= 1'b1;
    end

    task automatic send(input rmf_pkg::sample_t s, input logic frame_last);
        send_q.push_back('{s, frame_last});
    endtask

    // Wait until all words are sent and all outputs are in, then let the block drain
    task automatic settle();
        while (send_q.size() != 0 || sample_ch.valid || due_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_window(input logic [rmf_pkg::CFG_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        window_reg = v;
        @(negedge clk);
    endtask

    // Random phase of framed traffic; a few phases carry noisy frame marks
    task automatic random_phase(input int len);
        bit   noisy;
        int   frame_left;
        logic fl;
        noisy = ($urandom_range(0, 4) == 0);
        frame_left = frame_length();
        for (int i = 0; i < len; i++)
        begin
            if (noisy)
                fl = ($urandom_range(0, 3) == 0);
            else
            begin
                frame_left--;
                fl = (frame_left == 0);
                if (fl)
                    frame_left = frame_length();
            end
            send(pick_sample(), fl);
        end
    endtask

    initial
    begin : stimulus
        int sent;
        int len;
        int pick;
        logic [rmf_pkg::CFG_W-1:0] win_choices [16];
        sample_ch.valid         = 1'b0;
        sample_ch.sample        = '0;
        sample_ch.last_in_frame = 1'b0;
        result_ch.ready         = 1'b0;
        cfg_wr_en               = 1'b0;
        cfg_wr_data             = '0;
        rst_n                   = 1'b0;
        mismatch_count          = 0;
        send_gap                = 0;
        recv_gap                = 0;
        hold_cycles             = 0;
        steady                  = 1'b0;
        held_count              = 0;
        window_reg              = rmf_pkg::WINDOW_RESET;
        for (int k = 0; k < HIST_DEPTH; k++)
            out_history[k] = '0;
        for (int k = 0; k < RAW_DEPTH; k++)
            held_raw[k] = '0;
        win_choices = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd3, 8'd4, 8'd5, 8'd5,
                        8'd6, 8'd7, 8'd8, 8'd9, 8'd9, 8'd10, 8'd255, 8'd0};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset window: extremes, then a frame shorter than the history
        send(rmf_pkg::sample_t'(24'h7FFFFF), 1'b0);
        send(rmf_pkg::sample_t'(24'h800000), 1'b0);
        send(rmf_pkg::sample_t'(0), 1'b0);
        send(rmf_pkg::sample_t'(-1), 1'b0);
        send(rmf_pkg::sample_t'(1), 1'b1);
        send(rmf_pkg::sample_t'(100), 1'b1);
        settle();

        // Largest window: hold three words without output
        write_window(8'd9);
        send(rmf_pkg::sample_t'(24'h800000), 1'b0);
        send(rmf_pkg::sample_t'(24'h7FFFFF), 1'b0);
        send(rmf_pkg::sample_t'(5), 1'b0);
        settle();

        // Pass-through flushes the held words
        write_window(8'd1);
        send(rmf_pkg::sample_t'(-7), 1'b0);
        send(rmf_pkg::sample_t'(24'h7FFFFF), 1'b1);
        settle();

        // Shrink the window mid-frame
        write_window(8'd9);
        send(rmf_pkg::sample_t'(3), 1'b0);
        send(rmf_pkg::sample_t'(-3), 1'b0);
        settle();
        write_window(8'd3);
        send(rmf_pkg::sample_t'(7), 1'b0);
        settle();

        // Grow the window mid-frame, clamped from the top code
        write_window(8'd255);
        send(rmf_pkg::sample_t'(1), 1'b0);
        send(rmf_pkg::sample_t'(2), 1'b0);
        send(rmf_pkg::sample_t'(3), 1'b0);
        send(rmf_pkg::sample_t'(24'h800000), 1'b1);
        settle();

        write_window(8'd0);
        send(rmf_pkg::sample_t'(24'h7FFFFF), 1'b1);
        settle();
        write_window(8'd2);
        send(rmf_pkg::sample_t'(-1), 1'b0);
        settle();
        write_window(8'd4);
        send(rmf_pkg::sample_t'(10), 1'b0);
        send(rmf_pkg::sample_t'(20), 1'b0);
        send(rmf_pkg::sample_t'(-30), 1'b1);
        settle();
        write_window(8'd10);
        send(rmf_pkg::sample_t'(4), 1'b0);
        send(rmf_pkg::sample_t'(-4), 1'b1);
        settle();

        // Long receiver hold-off while the sender keeps offering words
        write_window(8'd3);
        steady = 1'b1;
        hold_cycles = LONG_HOLD_CYCLES;
        random_phase(40);
        sent = 40;
        settle();

        // Random phases with random windows and idling styles
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                pick = $urandom_range(0, 15);
                if (pick == 15)
                    write_window(rmf_pkg::CFG_W'($urandom_range(0, 255)));
                else
                    write_window(win_choices[pick]);
            end
            steady = ($urandom_range(0, 3) == 0);
            len = $urandom_range(8, 30);
            random_phase(len);
            sent += len;
            settle();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && due_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #(10_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/rmf_pkg.sv
rtl/core/rmf_channels.sv
rtl/core/rmf_sort_cell.sv
rtl/core/rmf_sorter.sv
rtl/core/recursive_median_filter_framed.sv
rtl/core/rmf_checker.sv
sim/recursive_median_filter_framed_tb.sv
